// ===== rtl/tasme_pkg.sv =====
// shared types and constants for the thumb add, subtract and multiply execute block
package tasme_pkg;

   localparam int unsigned DataWidth   = 32;
   localparam int unsigned RegIdxWidth = 4;
   localparam int unsigned NumRegs     = 15;
   localparam int unsigned QueueDepth  = 2;
   localparam int unsigned CycleWidth  = 6;
   localparam int unsigned ReqBits     = 56;
   localparam int unsigned RspBits     = 56;

   localparam logic [RegIdxWidth-1:0] PcIdx       = 4'd15;
   localparam logic [RegIdxWidth-1:0] SpIdx       = 4'd13;
   localparam logic [DataWidth-1:0]   PcAlignMask = 32'hFFFF_FFFC;
   localparam logic [CycleWidth-1:0]  CyclesOne   = 6'd1;
   localparam logic [CycleWidth-1:0]  CyclesPc    = 6'd2;
   localparam logic [CycleWidth-1:0]  CyclesMul   = 6'd32;

   typedef enum logic [3:0] {
      FUNC_ADCS    = 4'd0,
      FUNC_ADDS_I3 = 4'd1,
      FUNC_ADDS_I8 = 4'd2,
      FUNC_ADDS_R  = 4'd3,
      FUNC_ADD_R   = 4'd4,
      FUNC_ADD_SP  = 4'd5,
      FUNC_ADR     = 4'd6,
      FUNC_SUBS_I3 = 4'd7,
      FUNC_SUBS_I8 = 4'd8,
      FUNC_SUBS    = 4'd9,
      FUNC_SUB_SP  = 4'd10,
      FUNC_SBCS    = 4'd11,
      FUNC_RSBS    = 4'd12,
      FUNC_MULS    = 4'd13
   } func_type;

   typedef enum logic [2:0] {
      EXE_NONE,
      EXE_ADD,
      EXE_ADD_FLAGS,
      EXE_ADD_PC,
      EXE_MUL
   } exe_kind_type;

   typedef enum logic [1:0] {
      CIN_ZERO,
      CIN_ONE,
      CIN_CARRY
   } cin_type;

   typedef struct packed {
      exe_kind_type           kind;
      logic                   a_is_reg;
      logic [RegIdxWidth-1:0] addr_a;
      logic [DataWidth-1:0]   a_const;
      logic                   b_is_reg;
      logic [RegIdxWidth-1:0] addr_b;
      logic [DataWidth-1:0]   b_const;
      logic                   invert_b;
      cin_type                cin_sel;
      logic [RegIdxWidth-1:0] wr_reg;
      logic                   write_en;
      logic                   malformed;
   } decoded_type;

   typedef struct packed {
      logic n;
      logic z;
      logic c;
      logic v;
   } flags_type;

endpackage

// ===== rtl/tasme_ram.sv =====
// generic register file memory: one write port, two registered read ports
module tasme_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_a_ff;
   logic [WIDTH-1:0] rd_data_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_a_ff <= mem_ff[rd_addr_a];
         rd_data_b_ff <= mem_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

// ===== rtl/tasme_front.sv =====
// front end: unpacks an instruction item and classifies it into operand and operation selects
module tasme_front (
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [tasme_pkg::ReqBits-1:0] req_tdata,
   input  logic                       queue_full,
   output logic                       push,
   output tasme_pkg::decoded_type     push_item
);
   import tasme_pkg::*;

   logic [3:0]             func;
   logic [RegIdxWidth-1:0] dest_reg;
   logic [2:0]             first_reg;
   logic [RegIdxWidth-1:0] second_reg;
   logic [7:0]             immediate;
   logic [DataWidth-1:0]   pc_value;
   logic [RegIdxWidth-1:0] rn_idx;
   logic [DataWidth-1:0]   imm_word;
   logic [DataWidth-1:0]   imm_x4;

   assign func       = req_tdata[3:0];
   assign dest_reg   = req_tdata[7:4];
   assign first_reg  = req_tdata[10:8];
   assign second_reg = req_tdata[14:11];
   assign immediate  = req_tdata[22:15];
   assign pc_value   = req_tdata[54:23];

   assign rn_idx   = {1'b0, first_reg};
   assign imm_word = {24'd0, immediate};
   assign imm_x4   = {22'd0, immediate, 2'b00};

   assign req_tready = !queue_full;
   assign push       = req_tvalid && !queue_full;

   always_comb begin
      decoded_type d;
      logic        a_rd;
      logic        a_rn;
      logic        b_rm;
      logic        b_rn;
      d          = '0;
      d.kind     = EXE_NONE;
      d.cin_sel  = CIN_ZERO;
      d.wr_reg   = dest_reg;
      a_rd = 1'b0;
      a_rn = 1'b0;
      b_rm = 1'b0;
      b_rn = 1'b0;

      unique case (func)
         FUNC_ADCS: begin
            d.kind = EXE_ADD_FLAGS; a_rd = 1'b1; b_rm = 1'b1; d.cin_sel = CIN_CARRY;
         end
         FUNC_ADDS_I3: begin
            d.kind = EXE_ADD_FLAGS; a_rn = 1'b1; d.b_const = imm_word;
         end
         FUNC_ADDS_I8: begin
            d.kind = EXE_ADD_FLAGS; a_rd = 1'b1; d.b_const = imm_word;
         end
         FUNC_ADDS_R: begin
            d.kind = EXE_ADD_FLAGS; a_rn = 1'b1; b_rm = 1'b1;
         end
         FUNC_ADD_R: begin
            if (dest_reg == PcIdx && second_reg == PcIdx) begin
               d.malformed = 1'b1;
            end else begin
               d.kind = (dest_reg == PcIdx) ? EXE_ADD_PC : EXE_ADD;
               a_rd = 1'b1;
               b_rm = 1'b1;
            end
         end
         FUNC_ADD_SP: begin
            d.kind = EXE_ADD; d.a_is_reg = 1'b1; d.addr_a = SpIdx; d.b_const = imm_x4;
         end
         FUNC_ADR: begin
            d.kind = EXE_ADD; d.a_const = pc_value & PcAlignMask; d.b_const = imm_x4;
         end
         FUNC_SUBS_I3: begin
            d.kind = EXE_ADD_FLAGS; a_rn = 1'b1; d.b_const = imm_word;
            d.invert_b = 1'b1; d.cin_sel = CIN_ONE;
         end
         FUNC_SUBS_I8: begin
            d.kind = EXE_ADD_FLAGS; a_rd = 1'b1; d.b_const = imm_word;
            d.invert_b = 1'b1; d.cin_sel = CIN_ONE;
         end
         FUNC_SUBS: begin
            d.kind = EXE_ADD_FLAGS; a_rn = 1'b1; b_rm = 1'b1;
            d.invert_b = 1'b1; d.cin_sel = CIN_ONE;
         end
         FUNC_SUB_SP: begin
            d.kind = EXE_ADD; d.a_is_reg = 1'b1; d.addr_a = SpIdx; d.b_const = imm_x4;
            d.invert_b = 1'b1; d.cin_sel = CIN_ONE; d.wr_reg = SpIdx;
         end
         FUNC_SBCS: begin
            d.kind = EXE_ADD_FLAGS; a_rd = 1'b1; b_rm = 1'b1;
            d.invert_b = 1'b1; d.cin_sel = CIN_CARRY;
         end
         FUNC_RSBS: begin
            d.kind = EXE_ADD_FLAGS; b_rn = 1'b1;
            d.invert_b = 1'b1; d.cin_sel = CIN_ONE;
         end
         FUNC_MULS: begin
            d.kind = EXE_MUL; a_rd = 1'b1; b_rm = 1'b1;
         end
         default: begin
            d.kind = EXE_NONE;
         end
      endcase

      // r15 as an operand reads the fetch pc, so it turns into a constant here
      if (a_rn) begin
         d.a_is_reg = 1'b1;
         d.addr_a   = rn_idx;
      end else if (a_rd) begin
         if (dest_reg == PcIdx) begin
            d.a_const = pc_value;
         end else begin
            d.a_is_reg = 1'b1;
            d.addr_a   = dest_reg;
         end
      end

      if (b_rn) begin
         d.b_is_reg = 1'b1;
         d.addr_b   = rn_idx;
      end else if (b_rm) begin
         if (second_reg == PcIdx) begin
            d.b_const = pc_value;
         end else begin
            d.b_is_reg = 1'b1;
            d.addr_b   = second_reg;
         end
      end

      if (d.kind == EXE_NONE) begin
         d.wr_reg = '0;
      end
      d.write_en = (d.kind != EXE_NONE) && (d.kind != EXE_ADD_PC) && (d.wr_reg != PcIdx);
      push_item  = d;
   end

endmodule

// ===== rtl/tasme_queue.sv =====
// short queue of classified items between front and back
module tasme_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  tasme_pkg::decoded_type push_item,
   input  logic                   pop,
   output logic                   full,
   output logic                   head_valid,
   output tasme_pkg::decoded_type head_item
);
   import tasme_pkg::*;

   localparam int unsigned PtrWidth = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
   localparam int unsigned CntWidth = $clog2(QueueDepth + 1);

   decoded_type           slot_ff [QueueDepth];
   logic [PtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CntWidth-1:0]   count_ff, count_in;

   function automatic logic [PtrWidth-1:0] ptr_next(input logic [PtrWidth-1:0] p);
      if (p == PtrWidth'(QueueDepth - 1)) begin
         return '0;
      end
      return p + PtrWidth'(1);
   endfunction

   assign full       = (count_ff == CntWidth'(QueueDepth));
   assign head_valid = (count_ff != '0);
   assign head_item  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CntWidth'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CntWidth'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ===== rtl/tasme_back.sv =====
// back end: register file, flags, adder and multiplier, result register
module tasme_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          head_valid,
   input  tasme_pkg::decoded_type        head_item,
   output logic                          pop,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [tasme_pkg::RspBits-1:0] rsp_tdata
);
   import tasme_pkg::*;

   // execute stage
   logic                   e_valid_ff, e_valid_in;
   decoded_type            e_item_ff;
   logic                   e_fire;
   logic                   transfer;

   // operand read side data captured with the read
   logic                   vld_a_ff, vld_b_ff;
   logic                   hit_a_ff, hit_b_ff;
   logic [DataWidth-1:0]   fwd_data_ff;
   logic [DataWidth-1:0]   ram_a;
   logic [DataWidth-1:0]   ram_b;

   logic [NumRegs-1:0]     reg_vld_ff, reg_vld_in;
   flags_type              flags_ff, flags_in;

   // result register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [DataWidth-1:0]   rsp_value_ff;
   logic [RegIdxWidth-1:0] rsp_reg_ff;
   logic                   rsp_we_ff;
   logic                   rsp_pcw_ff;
   flags_type              rsp_flags_ff;
   logic [CycleWidth-1:0]  rsp_cycles_ff;
   logic                   rsp_bad_ff;

   logic [DataWidth-1:0]   a_val;
   logic [DataWidth-1:0]   b_val;
   logic [DataWidth-1:0]   b_eff;
   logic                   cin;
   logic [DataWidth:0]     sum;
   logic [DataWidth-1:0]   product;
   logic [DataWidth-1:0]   result;
   logic [CycleWidth-1:0]  cycles;
   logic                   wr_en;

   assign e_fire   = e_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign transfer = head_valid && (!e_valid_ff || e_fire);
   assign pop      = transfer;
   assign wr_en    = e_fire && e_item_ff.write_en;

   tasme_ram #(
      .WIDTH (DataWidth),
      .DEPTH (NumRegs)
   ) u_regfile (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (e_item_ff.wr_reg),
      .wr_data   (result),
      .rd_en     (transfer),
      .rd_addr_a (head_item.addr_a),
      .rd_addr_b (head_item.addr_b),
      .rd_data_a (ram_a),
      .rd_data_b (ram_b)
   );

   // a register never written still reads as zero; a write at the read edge is forwarded
   always_comb begin
      a_val = e_item_ff.a_const;
      if (e_item_ff.a_is_reg) begin
         a_val = hit_a_ff ? fwd_data_ff : (vld_a_ff ? ram_a : '0);
      end
      b_val = e_item_ff.b_const;
      if (e_item_ff.b_is_reg) begin
         b_val = hit_b_ff ? fwd_data_ff : (vld_b_ff ? ram_b : '0);
      end
      b_eff = e_item_ff.invert_b ? ~b_val : b_val;
      unique case (e_item_ff.cin_sel)
         CIN_ZERO:  cin = 1'b0;
         CIN_ONE:   cin = 1'b1;
         CIN_CARRY: cin = flags_ff.c;
         default:   cin = 1'b0;
      endcase
      sum     = {1'b0, a_val} + {1'b0, b_eff} + {{DataWidth{1'b0}}, cin};
      product = a_val * b_val;
   end

   always_comb begin
      result   = '0;
      cycles   = CyclesOne;
      flags_in = flags_ff;
      unique case (e_item_ff.kind)
         EXE_NONE: begin
            result = '0;
         end
         EXE_ADD: begin
            result = sum[DataWidth-1:0];
         end
         EXE_ADD_FLAGS: begin
            result     = sum[DataWidth-1:0];
            flags_in.n = result[DataWidth-1];
            flags_in.z = (result == '0);
            flags_in.c = sum[DataWidth];
            flags_in.v = (~(a_val[DataWidth-1] ^ b_eff[DataWidth-1]))
                         & (a_val[DataWidth-1] ^ result[DataWidth-1]);
         end
         EXE_ADD_PC: begin
            result = {sum[DataWidth-1:1], 1'b0};
            cycles = CyclesPc;
         end
         EXE_MUL: begin
            result     = product;
            cycles     = CyclesMul;
            flags_in.n = result[DataWidth-1];
            flags_in.z = (result == '0);
         end
         default: begin
            result = '0;
         end
      endcase
   end

   always_comb begin
      e_valid_in = e_valid_ff;
      if (transfer) begin
         e_valid_in = 1'b1;
      end else if (e_fire) begin
         e_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (e_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      reg_vld_in = reg_vld_ff;
      if (wr_en) begin
         reg_vld_in[e_item_ff.wr_reg] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         reg_vld_ff   <= '0;
         flags_ff     <= '0;
      end else begin
         e_valid_ff   <= e_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         reg_vld_ff   <= reg_vld_in;
         if (e_fire) begin
            flags_ff <= flags_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (transfer) begin
         e_item_ff   <= head_item;
         vld_a_ff    <= reg_vld_ff[head_item.addr_a];
         vld_b_ff    <= reg_vld_ff[head_item.addr_b];
         hit_a_ff    <= wr_en && (e_item_ff.wr_reg == head_item.addr_a);
         hit_b_ff    <= wr_en && (e_item_ff.wr_reg == head_item.addr_b);
         fwd_data_ff <= result;
      end
      if (e_fire) begin
         rsp_value_ff  <= result;
         rsp_reg_ff    <= e_item_ff.wr_reg;
         rsp_we_ff     <= e_item_ff.write_en;
         rsp_pcw_ff    <= (e_item_ff.kind == EXE_ADD_PC);
         rsp_flags_ff  <= flags_in;
         rsp_cycles_ff <= cycles;
         rsp_bad_ff    <= e_item_ff.malformed;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_bad_ff, rsp_cycles_ff,
                        rsp_flags_ff.v, rsp_flags_ff.c, rsp_flags_ff.z, rsp_flags_ff.n,
                        rsp_pcw_ff, rsp_we_ff, rsp_reg_ff, rsp_value_ff};

endmodule

// ===== rtl/thumb_add_sub_mul_execute.sv =====
// top level of the thumb add, subtract and multiply execute block
// Takes one decoded add, subtract or multiply instruction per clock while the queue has room
// and returns one result item per instruction. An item passes through the classifying front
// end into a two-entry queue, is read from the register file (r0 to r14, with read-side
// forwarding of the previous write) in the cycle it leaves the queue, and is executed into
// the result register when that register can take it. The register file and NZCV flags are
// updated as each item executes, so dependent instructions may follow back to back. The
// multiply is a combinational 32x32 unit; the cycle_count field reports architectural
// cycles only and does not throttle the block. Registers read as zero after reset through
// per-register valid bits, with no clearing pass.
module thumb_add_sub_mul_execute (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // func[3:0], dest_reg[7:4], first_reg[10:8], second_reg[14:11], immediate[22:15],
   // pc_value[54:23], zero[55]
   input  logic [55:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // write_value[31:0], write_reg[35:32], write_enable[36], pc_write[37], flag_n[38],
   // flag_z[39], flag_c[40], flag_v[41], cycle_count[47:42], malformed[48], zero[55:49]
   output logic [55:0] rsp_tdata
);
   import tasme_pkg::*;

   logic        queue_full;
   logic        push;
   decoded_type push_item;
   logic        pop;
   logic        head_valid;
   decoded_type head_item;

   tasme_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .queue_full (queue_full),
      .push       (push),
      .push_item  (push_item)
   );

   tasme_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_item  (push_item),
      .pop        (pop),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_item  (head_item)
   );

   tasme_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_item  (head_item),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
